@@ sv/bfz_pkg.sv @@
// shared constants and types for the 3x3 zero-padded box filter
package bfz_pkg;

   localparam int DEF_MAX_COLS   = 1024;
   localparam int DEF_PIXEL_BITS = 8;

   localparam int PIX_IN_W     = 8;
   localparam int ROW_W        = 12;
   localparam int OUT_COL_W    = 10;
   localparam int SUM_OUT_W    = 12;
   localparam int MEAN_W       = 16;
   localparam int MAX_ROWS     = 4096;
   localparam int FRAME_ROWS_W = 13;
   localparam int FRAME_COLS_W = 11;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

   localparam int JOB_DEPTH = 4;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_W = JOB_PTR_W + 1;
   localparam int SLOTS     = 4;

   typedef struct packed {
      logic             push;
      logic [SLOTS-1:0] mask;
   } job_ctrl_type;

endpackage

@@ sv/bfz_line_mem.sv @@
// three-row line store, one write port and two registered read ports
module bfz_line_mem #(
   parameter int DEPTH  = 3 * bfz_pkg::DEF_MAX_COLS,
   parameter int DATA_W = bfz_pkg::DEF_PIXEL_BITS,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr0,
   input  logic [ADDR_W-1:0] rd_addr1,
   output logic [DATA_W-1:0] rd_data0,
   output logic [DATA_W-1:0] rd_data1
);

   logic [DATA_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data0 <= mem_ff[rd_addr0];
         rd_data1 <= mem_ff[rd_addr1];
      end
   end

endmodule

@@ sv/bfz_window.sv @@
// frame position, line store access and column sums feeding the result jobs
module bfz_window #(
   parameter int MAX_COLS   = bfz_pkg::DEF_MAX_COLS,
   parameter int PIXEL_BITS = bfz_pkg::DEF_PIXEL_BITS,
   localparam int COL_W  = $clog2(MAX_COLS),
   localparam int SUM_W  = PIXEL_BITS + 4,
   localparam int ADDR_W = $clog2(3 * MAX_COLS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [bfz_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bfz_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                              req_valid,
   input  logic [bfz_pkg::PIX_IN_W-1:0]      req_pixel,
   output logic                              req_stall,
   input  logic [bfz_pkg::JOB_CNT_W-1:0]     jobs_used,
   output logic                              mem_wr_en,
   output logic [ADDR_W-1:0]                 mem_wr_addr,
   output logic [PIXEL_BITS-1:0]             mem_wr_data,
   output logic                              mem_rd_en,
   output logic [ADDR_W-1:0]                 mem_rd_addr0,
   output logic [ADDR_W-1:0]                 mem_rd_addr1,
   input  logic [PIXEL_BITS-1:0]             mem_rd_data0,
   input  logic [PIXEL_BITS-1:0]             mem_rd_data1,
   output bfz_pkg::job_ctrl_type             job_ctrl,
   output logic [bfz_pkg::ROW_W-1:0]         job_row,
   output logic [COL_W-1:0]                  job_col,
   output logic [bfz_pkg::SLOTS-1:0][SUM_W-1:0] job_sum
);
   import bfz_pkg::*;

   localparam logic [1:0] PHASE_LAST = 2'd2;

   typedef struct packed {
      logic r_ge1;
      logic r_ge2;
      logic c_ge1;
      logic c_ge2;
      logic last_col;
      logic last_row;
   } flags_type;

   function automatic logic [ADDR_W-1:0] row_base(input logic [1:0] ph);
      logic [ADDR_W-1:0] base;
      unique case (ph)
         2'd0:    base = '0;
         2'd1:    base = ADDR_W'(MAX_COLS);
         default: base = ADDR_W'(2 * MAX_COLS);
      endcase
      return base;
   endfunction

   logic [ROW_W-1:0]  last_row_ff, last_row_in;
   logic [COL_W-1:0]  last_col_ff, last_col_in;
   logic [ROW_W-1:0]  row_pos_ff, row_pos_in;
   logic [COL_W-1:0]  col_pos_ff, col_pos_in;
   logic [1:0]        phase_ff, phase_in;

   logic              s1_valid_ff;
   logic [PIXEL_BITS-1:0] s1_pix_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [COL_W-1:0]  s1_col_ff;
   flags_type         s1_flags_ff;

   logic              s2_valid_ff;
   logic [SUM_W-1:0]  s2_a_ff, s2_b_ff;
   logic [ROW_W-1:0]  s2_row_ff;
   logic [COL_W-1:0]  s2_col_ff;
   flags_type         s2_flags_ff;

   logic [SUM_W-1:0]  a1_ff, a2_ff, b1_ff, b2_ff;

   logic              cfg_row_we, cfg_col_we, cfg_we;
   logic [FRAME_ROWS_W-1:0] rows_raw;
   logic [FRAME_COLS_W-1:0] cols_raw;
   logic [ROW_W-1:0]  rows_last;
   logic [COL_W-1:0]  cols_last;
   logic              accept;
   logic              at_last_col, at_last_row;
   logic [1:0]        phase_m1, phase_m2;
   logic [PIXEL_BITS+PIX_IN_W-1:0] pix_ext;
   logic [JOB_CNT_W-1:0] pending;
   flags_type         flags_now;
   logic [SUM_W-1:0]  col_a, col_b;
   logic [SUM_W-1:0]  a_l1, a_l2, b_l1, b_l2;

   // configuration decode
   always_comb begin
      cfg_row_we = csr_valid && (csr_index == REG_FRAME_ROWS);
      cfg_col_we = csr_valid && (csr_index == REG_FRAME_COLS);
      cfg_we     = cfg_row_we || cfg_col_we;
      rows_raw   = csr_data[FRAME_ROWS_W-1:0];
      cols_raw   = csr_data[FRAME_COLS_W-1:0];
      priority if (rows_raw == '0) begin
         rows_last = '0;
      end else if (rows_raw > FRAME_ROWS_W'(MAX_ROWS)) begin
         rows_last = ROW_W'(MAX_ROWS - 1);
      end else begin
         rows_last = ROW_W'(rows_raw - 1'b1);
      end
      priority if (cols_raw == '0) begin
         cols_last = '0;
      end else if (32'(cols_raw) > 32'(MAX_COLS)) begin
         cols_last = COL_W'(MAX_COLS - 1);
      end else begin
         cols_last = COL_W'(cols_raw - 1'b1);
      end
   end

   assign pending   = jobs_used + JOB_CNT_W'(s1_valid_ff) + JOB_CNT_W'(s2_valid_ff);
   assign req_stall = pending >= JOB_CNT_W'(JOB_DEPTH);
   assign accept    = req_valid && !req_stall;

   assign at_last_col = col_pos_ff == last_col_ff;
   assign at_last_row = row_pos_ff == last_row_ff;

   always_comb begin
      last_row_in = cfg_row_we ? rows_last : last_row_ff;
      last_col_in = cfg_col_we ? cols_last : last_col_ff;
      row_pos_in  = row_pos_ff;
      col_pos_in  = col_pos_ff;
      phase_in    = phase_ff;
      priority if (cfg_we) begin
         row_pos_in = '0;
         col_pos_in = '0;
         phase_in   = '0;
      end else if (accept) begin
         if (at_last_col) begin
            col_pos_in = '0;
            if (at_last_row) begin
               row_pos_in = '0;
               phase_in   = '0;
            end else begin
               row_pos_in = row_pos_ff + 1'b1;
               phase_in   = (phase_ff == PHASE_LAST) ? 2'd0 : phase_ff + 2'd1;
            end
         end else begin
            col_pos_in = col_pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_row_ff <= '0;
         last_col_ff <= '0;
         row_pos_ff  <= '0;
         col_pos_ff  <= '0;
         phase_ff    <= '0;
      end else begin
         last_row_ff <= last_row_in;
         last_col_ff <= last_col_in;
         row_pos_ff  <= row_pos_in;
         col_pos_ff  <= col_pos_in;
         phase_ff    <= phase_in;
      end
   end

   // rows r-1 and r-2 of the store, modulo three
   assign phase_m1 = (phase_ff == 2'd0) ? PHASE_LAST : phase_ff - 2'd1;
   assign phase_m2 = (phase_ff == PHASE_LAST) ? 2'd0 : phase_ff + 2'd1;
   assign pix_ext  = {{PIXEL_BITS{1'b0}}, req_pixel};

   assign mem_wr_en    = accept;
   assign mem_wr_addr  = row_base(phase_ff) + ADDR_W'(col_pos_ff);
   assign mem_wr_data  = pix_ext[PIXEL_BITS-1:0];
   assign mem_rd_en    = accept;
   assign mem_rd_addr0 = row_base(phase_m1) + ADDR_W'(col_pos_ff);
   assign mem_rd_addr1 = row_base(phase_m2) + ADDR_W'(col_pos_ff);

   always_comb begin
      flags_now.r_ge1    = row_pos_ff != '0;
      flags_now.r_ge2    = row_pos_ff > ROW_W'(1);
      flags_now.c_ge1    = col_pos_ff != '0;
      flags_now.c_ge2    = col_pos_ff > COL_W'(1);
      flags_now.last_col = at_last_col;
      flags_now.last_row = at_last_row;
   end

   // stage 1: column sums from the new pixel and the two rows above
   assign col_b = SUM_W'(s1_pix_ff) + (s1_flags_ff.r_ge1 ? SUM_W'(mem_rd_data0) : '0);
   assign col_a = col_b + (s1_flags_ff.r_ge2 ? SUM_W'(mem_rd_data1) : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= pix_ext[PIXEL_BITS-1:0];
         s1_row_ff   <= row_pos_ff;
         s1_col_ff   <= col_pos_ff;
         s1_flags_ff <= flags_now;
      end
      if (s1_valid_ff) begin
         s2_a_ff     <= col_a;
         s2_b_ff     <= col_b;
         s2_row_ff   <= s1_row_ff;
         s2_col_ff   <= s1_col_ff;
         s2_flags_ff <= s1_flags_ff;
      end
      if (s2_valid_ff) begin
         a1_ff <= s2_a_ff;
         a2_ff <= a1_ff;
         b1_ff <= s2_b_ff;
         b2_ff <= b1_ff;
      end
   end

   // stage 2: window sums over the last three columns, or the last two for slots 1 and 3
   assign a_l1 = s2_flags_ff.c_ge1 ? a1_ff : '0;
   assign a_l2 = s2_flags_ff.c_ge2 ? a2_ff : '0;
   assign b_l1 = s2_flags_ff.c_ge1 ? b1_ff : '0;
   assign b_l2 = s2_flags_ff.c_ge2 ? b2_ff : '0;

   always_comb begin
      job_sum[0] = s2_a_ff + a_l1 + a_l2;
      job_sum[1] = s2_a_ff + a_l1;
      job_sum[2] = s2_b_ff + b_l1 + b_l2;
      job_sum[3] = s2_b_ff + b_l1;
      job_ctrl.mask[0] = s2_flags_ff.r_ge1 && s2_flags_ff.c_ge1;
      job_ctrl.mask[1] = s2_flags_ff.r_ge1 && s2_flags_ff.last_col;
      job_ctrl.mask[2] = s2_flags_ff.last_row && s2_flags_ff.c_ge1;
      job_ctrl.mask[3] = s2_flags_ff.last_row && s2_flags_ff.last_col;
      job_ctrl.push    = s2_valid_ff && (job_ctrl.mask != '0);
   end

   assign job_row = s2_row_ff;
   assign job_col = s2_col_ff;

endmodule

@@ sv/bfz_emit.sv @@
// job queue, result sequencing, divide by nine and the output register
module bfz_emit #(
   parameter int MAX_COLS   = bfz_pkg::DEF_MAX_COLS,
   parameter int PIXEL_BITS = bfz_pkg::DEF_PIXEL_BITS,
   localparam int COL_W = $clog2(MAX_COLS),
   localparam int SUM_W = PIXEL_BITS + 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bfz_pkg::job_ctrl_type                job_ctrl,
   input  logic [bfz_pkg::ROW_W-1:0]            job_row,
   input  logic [COL_W-1:0]                     job_col,
   input  logic [bfz_pkg::SLOTS-1:0][SUM_W-1:0] job_sum,
   output logic [bfz_pkg::JOB_CNT_W-1:0]        jobs_used,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bfz_pkg::ROW_W-1:0]            rsp_out_row,
   output logic [bfz_pkg::OUT_COL_W-1:0]        rsp_out_col,
   output logic [bfz_pkg::SUM_OUT_W-1:0]        rsp_box_sum,
   output logic [bfz_pkg::MEAN_W-1:0]           rsp_mean_q8,
   output logic                                 rsp_run_last
);
   import bfz_pkg::*;

   localparam int XW = SUM_W + 8;
   localparam int K  = XW + 4;
   localparam int PW = XW + K;
   localparam logic [K-1:0] RECIP = K'(((64'd1 << K) / 64'd9) + 64'd1);

   logic [SLOTS-1:0][SUM_W-1:0] q_sum_ff  [JOB_DEPTH];
   logic [SLOTS-1:0]            q_mask_ff [JOB_DEPTH];
   logic [ROW_W-1:0]            q_row_ff  [JOB_DEPTH];
   logic [COL_W-1:0]            q_col_ff  [JOB_DEPTH];

   logic [JOB_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0] used_ff, used_in;
   logic [SLOTS-1:0]     done_ff, done_in;

   logic                 e_valid_ff, e_valid_in;
   logic [SUM_W-1:0]     e_sum_ff;
   logic [ROW_W-1:0]     e_row_ff;
   logic [COL_W-1:0]     e_col_ff;
   logic                 e_last_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]     rsp_row_ff;
   logic [OUT_COL_W-1:0] rsp_col_ff;
   logic [SUM_OUT_W-1:0] rsp_sum_ff;
   logic [MEAN_W-1:0]    rsp_mean_ff;
   logic                 rsp_last_ff;

   logic [SLOTS-1:0]     remaining, pick_oh;
   logic [1:0]           pick;
   logic                 have, is_last, adv, e_ready, take, pop;
   logic [SUM_W-1:0]     pick_sum;
   logic [ROW_W-1:0]     pick_row;
   logic [COL_W-1:0]     pick_col;
   logic [XW-1:0]        x;
   logic [PW-1:0]        prod;
   logic [XW+MEAN_W-1:0] quot_ext;
   logic [COL_W+OUT_COL_W-1:0] col_ext;
   logic [SUM_W+SUM_OUT_W-1:0] sum_ext;

   // next result of the head job, in emission order
   assign remaining = (used_ff != '0) ? (q_mask_ff[rd_ptr_ff] & ~done_ff) : '0;
   assign have      = remaining != '0;

   always_comb begin
      priority if (remaining[0]) begin
         pick = 2'd0;
      end else if (remaining[1]) begin
         pick = 2'd1;
      end else if (remaining[2]) begin
         pick = 2'd2;
      end else begin
         pick = 2'd3;
      end
      pick_oh  = SLOTS'(1) << pick;
      is_last  = (remaining & ~pick_oh) == '0;
      pick_sum = q_sum_ff[rd_ptr_ff][pick];
      pick_row = pick[1] ? q_row_ff[rd_ptr_ff] : q_row_ff[rd_ptr_ff] - 1'b1;
      pick_col = pick[0] ? q_col_ff[rd_ptr_ff] : q_col_ff[rd_ptr_ff] - 1'b1;
   end

   assign adv     = !rsp_valid_ff || !rsp_stall;
   assign e_ready = !e_valid_ff || adv;
   assign take    = e_ready && have;
   assign pop     = take && is_last;

   always_comb begin
      wr_ptr_in    = job_ctrl.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      used_in      = used_ff + JOB_CNT_W'(job_ctrl.push) - JOB_CNT_W'(pop);
      done_in      = pop ? '0 : (take ? (done_ff | pick_oh) : done_ff);
      e_valid_in   = e_ready ? have : e_valid_ff;
      rsp_valid_in = adv ? e_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         used_ff      <= '0;
         done_ff      <= '0;
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         used_ff      <= used_in;
         done_ff      <= done_in;
         e_valid_ff   <= e_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_ctrl.push) begin
         q_sum_ff[wr_ptr_ff]  <= job_sum;
         q_mask_ff[wr_ptr_ff] <= job_ctrl.mask;
         q_row_ff[wr_ptr_ff]  <= job_row;
         q_col_ff[wr_ptr_ff]  <= job_col;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         e_sum_ff  <= pick_sum;
         e_row_ff  <= pick_row;
         e_col_ff  <= pick_col;
         e_last_ff <= is_last;
      end
   end

   // (sum*256 + 4) / 9 by reciprocal multiply
   assign x        = {e_sum_ff, 8'd4};
   assign prod     = PW'(x) * PW'(RECIP);
   assign quot_ext = {{MEAN_W{1'b0}}, prod[PW-1:K]};
   assign col_ext  = {{OUT_COL_W{1'b0}}, e_col_ff};
   assign sum_ext  = {{SUM_OUT_W{1'b0}}, e_sum_ff};

   always_ff @(posedge clock) begin
      if (adv && e_valid_ff) begin
         rsp_row_ff  <= e_row_ff;
         rsp_col_ff  <= col_ext[OUT_COL_W-1:0];
         rsp_sum_ff  <= sum_ext[SUM_OUT_W-1:0];
         rsp_mean_ff <= quot_ext[MEAN_W-1:0];
         rsp_last_ff <= e_last_ff;
      end
   end

   assign jobs_used    = used_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_row  = rsp_row_ff;
   assign rsp_out_col  = rsp_col_ff;
   assign rsp_box_sum  = rsp_sum_ff;
   assign rsp_mean_q8  = rsp_mean_ff;
   assign rsp_run_last = rsp_last_ff;

endmodule

@@ sv/box_filter_3x3_zero_pad.sv @@
// top level of the 3x3 zero-padded box filter
//
//   port group   direction   handshake           payload
//   req_         in          req_valid/stall     pixel
//   rsp_         out         rsp_valid/stall     out_row, out_col, box_sum, mean_q8, run_last
//   csr_         in          csr_valid/ready     index, data
//
// one pixel per cycle until results back up; sustained, intake follows the results sent
// each pixel yields 0 to 4 results, sent one per cycle while rsp_stall is low
// req_stall rises when queued jobs plus pixels in the two column-sum stages reach 4
// synchronous reset clears position, frame size and all valid flags; no memory clearing
// rsp_stall holds the output register; the queue keeps taking pixels until full
module box_filter_3x3_zero_pad #(
   parameter int MAX_COLS   = bfz_pkg::DEF_MAX_COLS,
   parameter int PIXEL_BITS = bfz_pkg::DEF_PIXEL_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bfz_pkg::PIX_IN_W-1:0]      req_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bfz_pkg::ROW_W-1:0]         rsp_out_row,
   output logic [bfz_pkg::OUT_COL_W-1:0]     rsp_out_col,
   output logic [bfz_pkg::SUM_OUT_W-1:0]     rsp_box_sum,
   output logic [bfz_pkg::MEAN_W-1:0]        rsp_mean_q8,
   output logic                              rsp_run_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bfz_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bfz_pkg::CSR_DATA_W-1:0]    csr_data
);
   import bfz_pkg::*;

   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int SUM_W  = PIXEL_BITS + 4;
   localparam int DEPTH  = 3 * MAX_COLS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic                  mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]     mem_wr_addr, mem_rd_addr0, mem_rd_addr1;
   logic [PIXEL_BITS-1:0] mem_wr_data, mem_rd_data0, mem_rd_data1;
   job_ctrl_type          job_ctrl;
   logic [ROW_W-1:0]      job_row;
   logic [COL_W-1:0]      job_col;
   logic [SLOTS-1:0][SUM_W-1:0] job_sum;
   logic [JOB_CNT_W-1:0]  jobs_used;

   assign csr_ready = 1'b1;

   bfz_line_mem #(
      .DEPTH  (DEPTH),
      .DATA_W (PIXEL_BITS)
   ) u_line_mem (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_data  (mem_wr_data),
      .rd_en    (mem_rd_en),
      .rd_addr0 (mem_rd_addr0),
      .rd_addr1 (mem_rd_addr1),
      .rd_data0 (mem_rd_data0),
      .rd_data1 (mem_rd_data1)
   );

   bfz_window #(
      .MAX_COLS   (MAX_COLS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_pixel    (req_pixel),
      .req_stall    (req_stall),
      .jobs_used    (jobs_used),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr0 (mem_rd_addr0),
      .mem_rd_addr1 (mem_rd_addr1),
      .mem_rd_data0 (mem_rd_data0),
      .mem_rd_data1 (mem_rd_data1),
      .job_ctrl     (job_ctrl),
      .job_row      (job_row),
      .job_col      (job_col),
      .job_sum      (job_sum)
   );

   bfz_emit #(
      .MAX_COLS   (MAX_COLS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_emit (
      .clock        (clock),
      .reset        (reset),
      .job_ctrl     (job_ctrl),
      .job_row      (job_row),
      .job_col      (job_col),
      .job_sum      (job_sum),
      .jobs_used    (jobs_used),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_row  (rsp_out_row),
      .rsp_out_col  (rsp_out_col),
      .rsp_box_sum  (rsp_box_sum),
      .rsp_mean_q8  (rsp_mean_q8),
      .rsp_run_last (rsp_run_last)
   );

endmodule

@@ sv/bfz_checker.sv @@
// port-level checks for the box filter, attached by bind
module bfz_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [bfz_pkg::ROW_W-1:0]     rsp_out_row,
   input logic [bfz_pkg::OUT_COL_W-1:0] rsp_out_col,
   input logic [bfz_pkg::SUM_OUT_W-1:0] rsp_box_sum,
   input logic [bfz_pkg::MEAN_W-1:0]    rsp_mean_q8,
   input logic                          rsp_run_last
);
   import bfz_pkg::*;

   logic [31:0] mean_x9;
   logic [31:0] sum_scaled;

   assign mean_x9    = 32'(rsp_mean_q8) * 32'd9;
   assign sum_scaled = (32'(rsp_box_sum) << 8) + 32'd4;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_row) && $stable(rsp_out_col)
         && $stable(rsp_box_sum) && $stable(rsp_mean_q8) && $stable(rsp_run_last))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_mean_round: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (mean_x9 <= sum_scaled) && (sum_scaled < mean_x9 + 32'd9))
      else $error("mean does not match box sum");

   a_corner_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_row == '0) && (rsp_out_col == '0) |-> rsp_box_sum <= 12'd1020)
      else $error("corner sum exceeds four pixels");

endmodule

bind box_filter_3x3_zero_pad bfz_checker u_bfz_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_row  (rsp_out_row),
   .rsp_out_col  (rsp_out_col),
   .rsp_box_sum  (rsp_box_sum),
   .rsp_mean_q8  (rsp_mean_q8),
   .rsp_run_last (rsp_run_last)
);

@@ tb/box_mean_checker.sv @@
// checker for the 3x3 zero-padded box filter: tracks the frame, predicts each filtered pixel
module box_mean_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [bfz_pkg::PIX_IN_W-1:0]   req_pixel,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [bfz_pkg::ROW_W-1:0]      rsp_out_row,
   input  logic [bfz_pkg::OUT_COL_W-1:0]  rsp_out_col,
   input  logic [bfz_pkg::SUM_OUT_W-1:0]  rsp_box_sum,
   input  logic [bfz_pkg::MEAN_W-1:0]     rsp_mean_q8,
   input  logic                           rsp_run_last,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [bfz_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfz_pkg::CSR_DATA_W-1:0] csr_data,
   output int                             fail_count,
   output int                             due_count,
   output int                             seen_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import bfz_pkg::*;

   localparam int LINE_LEN = DEF_MAX_COLS;

   typedef struct packed {
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
      logic [SUM_OUT_W-1:0] sum;
      logic [MEAN_W-1:0]    mean;
      logic                 last;
   } filt_pixel_type;

   logic [DEF_PIXEL_BITS-1:0] line_mem [3][LINE_LEN];
   logic [FRAME_ROWS_W-1:0]   rows_cfg;
   logic [FRAME_COLS_W-1:0]   cols_cfg;
   int                        row_at;
   int                        col_at;
   filt_pixel_type            due_outputs[$];

   initial begin
      fail_count = 0;
      seen_count = 0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < LINE_LEN; j++) begin
            line_mem[i][j] = '0;
         end
      end
   end

   function automatic int frame_height();
      if (rows_cfg == 0) begin
         return 1;
      end
      if (rows_cfg > MAX_ROWS) begin
         return MAX_ROWS;
      end
      return int'(rows_cfg);
   endfunction

   function automatic int frame_width();
      if (cols_cfg == 0) begin
         return 1;
      end
      if (cols_cfg > LINE_LEN) begin
         return LINE_LEN;
      end
      return int'(cols_cfg);
   endfunction

   function automatic int nbhd_sum(input int orow, input int ocol, input int nr, input int nc);
      int acc;
      int rr;
      int cc;
      acc = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            rr = orow + dr;
            cc = ocol + dc;
            if (rr >= 0 && rr < nr && cc >= 0 && cc < nc) begin
               acc += line_mem[rr % 3][cc];
            end
         end
      end
      return acc;
   endfunction

   task automatic queue_filtered(input int orow, input int ocol, input int nr, input int nc);
      filt_pixel_type e;
      int s;
      s = nbhd_sum(orow, ocol, nr, nc);
      e.row  = ROW_W'(orow);
      e.col  = OUT_COL_W'(ocol);
      e.sum  = SUM_OUT_W'(s);
      e.mean = MEAN_W'((s * 256 + 4) / 9);
      e.last = 1'b0;
      due_outputs.push_back(e);
   endtask

   task automatic predict_pixel(input logic [PIX_IN_W-1:0] px);
      int nr;
      int nc;
      int r;
      int c;
      int before_cnt;
      bit end_col;
      bit end_row;
      filt_pixel_type tail;
      nr = frame_height();
      nc = frame_width();
      r = (row_at >= nr) ? nr - 1 : row_at;
      c = (col_at >= nc) ? nc - 1 : col_at;
      line_mem[r % 3][c] = px[DEF_PIXEL_BITS-1:0];
      end_col = (c == nc - 1);
      end_row = (r == nr - 1);
      before_cnt = due_outputs.size();
      if (r >= 1 && c >= 1) begin
         queue_filtered(r - 1, c - 1, nr, nc);
      end
      if (r >= 1 && end_col) begin
         queue_filtered(r - 1, nc - 1, nr, nc);
      end
      if (end_row && c >= 1) begin
         queue_filtered(r, c - 1, nr, nc);
      end
      if (end_row && end_col) begin
         queue_filtered(r, nc - 1, nr, nc);
      end
      if (due_outputs.size() > before_cnt) begin
         tail = due_outputs.pop_back();
         tail.last = 1'b1;
         due_outputs.push_back(tail);
      end
      if (end_col) begin
         col_at = 0;
         row_at = end_row ? 0 : r + 1;
      end else begin
         col_at = c + 1;
         row_at = r;
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      filt_pixel_type want;
      if (reset) begin
         due_outputs.delete();
         rows_cfg = 1;
         cols_cfg = 1;
         row_at = 0;
         col_at = 0;
         due_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_FRAME_ROWS) begin
               rows_cfg = csr_data[FRAME_ROWS_W-1:0];
               row_at = 0;
               col_at = 0;
            end else if (csr_index == REG_FRAME_COLS) begin
               cols_cfg = csr_data[FRAME_COLS_W-1:0];
               row_at = 0;
               col_at = 0;
            end
         end
         if (req_valid && !req_stall) begin
            predict_pixel(req_pixel);
         end
         if (rsp_valid && !rsp_stall) begin
            seen_count++;
            if (due_outputs.size() == 0) begin
               report_mismatch($sformatf("result at row %0d col %0d with nothing expected",
                                         rsp_out_row, rsp_out_col));
            end else begin
               want = due_outputs.pop_front();
               if (rsp_out_row !== want.row) begin
                  report_mismatch($sformatf("out_row %0d, expected %0d", rsp_out_row, want.row));
               end
               if (rsp_out_col !== want.col) begin
                  report_mismatch($sformatf("out_col %0d, expected %0d", rsp_out_col, want.col));
               end
               if (rsp_box_sum !== want.sum) begin
                  report_mismatch($sformatf("box_sum %0d, expected %0d at (%0d,%0d)",
                                            rsp_box_sum, want.sum, want.row, want.col));
               end
               if (rsp_mean_q8 !== want.mean) begin
                  report_mismatch($sformatf("mean_q8 %0d, expected %0d at (%0d,%0d)",
                                            rsp_mean_q8, want.mean, want.row, want.col));
               end
               if (rsp_run_last !== want.last) begin
                  report_mismatch($sformatf("run_last %0b, expected %0b at (%0d,%0d)",
                                            rsp_run_last, want.last, want.row, want.col));
               end
            end
         end
         due_count <= due_outputs.size();
      end
   end

endmodule

@@ tb/tb.sv @@
// testbench top for the 3x3 zero-padded box filter: stimulus, backpressure and verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bfz_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 2'd3;
   localparam int HOLD_CYCLES   = 100;
   localparam int RANDOM_PIXELS = 100;
   localparam int EXTREME_PIXELS = 12;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [PIX_IN_W-1:0]   req_pixel;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [ROW_W-1:0]      rsp_out_row;
   logic [OUT_COL_W-1:0]  rsp_out_col;
   logic [SUM_OUT_W-1:0]  rsp_box_sum;
   logic [MEAN_W-1:0]     rsp_mean_q8;
   logic                  rsp_run_last;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int fail_count;
   int due_count;
   int seen_count;
   int px_sent = 0;
   int settings = 0;
   bit calm = 1'b0;
   bit hold_req = 1'b0;
   bit hold_done = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   box_filter_3x3_zero_pad u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pixel    (req_pixel),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_row  (rsp_out_row),
      .rsp_out_col  (rsp_out_col),
      .rsp_box_sum  (rsp_box_sum),
      .rsp_mean_q8  (rsp_mean_q8),
      .rsp_run_last (rsp_run_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   box_mean_checker u_chk (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pixel    (req_pixel),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_row  (rsp_out_row),
      .rsp_out_col  (rsp_out_col),
      .rsp_box_sum  (rsp_box_sum),
      .rsp_mean_q8  (rsp_mean_q8),
      .rsp_run_last (rsp_run_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .due_count    (due_count),
      .seen_count   (seen_count)
   );

   initial begin
      #1000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver backpressure, with one long hold-off
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 26);
      end
   end

   function automatic logic [PIX_IN_W-1:0] rand_pixel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return PIX_IN_W'($urandom());
      endcase
   endfunction

   task automatic offer_pixel(input logic [PIX_IN_W-1:0] px);
      while (!calm && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      px_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame(input int rows, input int cols);
      if ($urandom_range(0, 1)) begin
         write_reg(REG_FRAME_ROWS, CSR_DATA_W'(rows));
         write_reg(REG_FRAME_COLS, CSR_DATA_W'(cols));
      end else begin
         write_reg(REG_FRAME_COLS, CSR_DATA_W'(cols));
         write_reg(REG_FRAME_ROWS, CSR_DATA_W'(rows));
      end
      settings++;
   endtask

   // drain everything outstanding, then let pixels with no output leave the pipeline
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      repeat (count) offer_pixel(rand_pixel());
      settle();
   endtask

   initial begin
      int rows;
      int cols;
      int fr;
      int fc;
      int n;
      int rand_sent;
      int phase;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_pixel <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset frame size is 1x1
      offer_pixel(8'h00);
      offer_pixel(8'hFF);
      settle();
      // zero sizes act as 1x1
      set_frame(0, 0);
      offer_pixel(8'hA5);
      settle();
      // full-scale 3x3 frame, then wrap into the next frame
      set_frame(3, 3);
      repeat (9) offer_pixel(8'hFF);
      offer_pixel(8'h55);
      offer_pixel(8'hAA);
      settle();
      // unused indexes must not restart the frame
      write_reg(REG_SPARE_A, '1);
      write_reg(REG_SPARE_B, '0);
      offer_pixel(8'h01);
      offer_pixel(8'h02);
      offer_pixel(8'h04);
      offer_pixel(8'h08);
      offer_pixel(8'h10);
      offer_pixel(8'h20);
      offer_pixel(8'h40);
      settle();

      // size extremes
      set_frame(MAX_ROWS, 1);
      send_random(EXTREME_PIXELS);
      set_frame(1, DEF_MAX_COLS);
      send_random(EXTREME_PIXELS);
      set_frame(1, 2047);
      send_random(EXTREME_PIXELS);
      set_frame(8191, 2);
      send_random(EXTREME_PIXELS);

      // long receiver hold-off while pixels keep coming
      set_frame(4, 4);
      hold_req = 1'b1;
      send_random(32);

      rand_sent = 0;
      phase = 0;
      while (rand_sent < RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0: begin
               rows = $urandom_range(0, 8191);
               cols = $urandom_range(0, 6);
            end
            1: begin
               rows = $urandom_range(0, 2);
               cols = $urandom_range(0, 8191);
            end
            default: begin
               rows = $urandom_range(0, 6);
               cols = $urandom_range(0, 6);
            end
         endcase
         set_frame(rows, cols);
         if ($urandom_range(0, 4) == 0) begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CSR_DATA_W'($urandom()));
         end
         fr = (rows == 0) ? 1 : (rows > MAX_ROWS ? MAX_ROWS : rows);
         fc = (cols[FRAME_COLS_W-1:0] == 0) ? 1 : int'(cols[FRAME_COLS_W-1:0]);
         if (fr * fc <= 40 && $urandom_range(0, 3) != 0) begin
            n = fr * fc * $urandom_range(1, 2) + $urandom_range(0, 2);
         end else begin
            n = $urandom_range(4, 40);
         end
         calm = (phase == 0);
         if (calm) begin
            n = 60;
         end
         send_random(n);
         calm = 1'b0;
         rand_sent += n;
         phase++;
      end

      settle();
      $display("sent %0d pixels over %0d frame sizes, incl. zero, oversize and spare-index writes",
               px_sent, settings);
      $display("checked %0d filtered pixels, with one %0d-cycle receiver hold-off",
               seen_count, HOLD_CYCLES);
      if (fail_count == 0 && due_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
